@@ src/tasm_pkg.sv @@
`timescale 1ns / 1ps

package tasm_pkg;

  localparam int PERIOD_W = 16;
  localparam int WAIT_W   = 17;
  localparam int PHASE_W  = 3;
  localparam int MOVE_W   = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RESET = 16'd10000;

  // register indexes
  localparam logic REG_STEP_PERIOD = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_OFF  = 2'd2
  } op_t;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic wait_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic start_div;
    logic div_done;
    logic out_free;
  } status_t;

  // half-step coil sequence
  function automatic logic [3:0] coil_pattern(input logic [PHASE_W-1:0] ph);
    logic [3:0] pat;
    case (ph)
      3'd0:    pat = 4'd1;
      3'd1:    pat = 4'd5;
      3'd2:    pat = 4'd4;
      3'd3:    pat = 4'd6;
      3'd4:    pat = 4'd2;
      3'd5:    pat = 4'd10;
      3'd6:    pat = 4'd8;
      default: pat = 4'd9;
    endcase
    return pat;
  endfunction

endpackage

@@ src/tasm_if.sv @@
`timescale 1ns / 1ps

interface tasm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;

  modport source (output valid, operation, move_x, move_y, input ready);
  modport sink (input valid, operation, move_x, move_y, output ready);
endinterface

interface tasm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] x_coils;
  logic [3:0] y_coils;
  logic [1:0] stepped_axis;
  logic       busy_res;
  logic       move_done;
  logic       rejected;

  modport source (output valid, x_coils, y_coils, stepped_axis, busy_res, move_done,
                  rejected, input ready);
  modport sink (input valid, x_coils, y_coils, stepped_axis, busy_res, move_done,
                rejected, output ready);
endinterface

@@ src/tasm_div.sv @@
`timescale 1ns / 1ps

module tasm_div #(
  parameter int MOVE_BITS = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tasm_pkg::PERIOD_W-1:0]   period,
  input  logic [MOVE_BITS-1:0]            minor,
  input  logic [MOVE_BITS-1:0]            major,
  output logic                            done,
  output logic [tasm_pkg::PERIOD_W-1:0]   quotient
);

  localparam int DW = tasm_pkg::PERIOD_W + MOVE_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]        quot_r;
  logic [MOVE_BITS-1:0] rem_r;
  logic [CW-1:0]        cnt_r;
  logic [DW-1:0]        prod;
  logic [MOVE_BITS:0]   trial;
  logic                 fits;

  assign prod  = DW'(period) * DW'(minor);
  assign trial = {rem_r, quot_r[DW-1]};
  assign fits  = (trial >= {1'b0, major});

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(DW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= prod;
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      quot_r <= {quot_r[DW-2:0], fits};
      rem_r  <= fits ? MOVE_BITS'(trial - {1'b0, major}) : trial[MOVE_BITS-1:0];
    end
  end

  // quotient never exceeds period since minor <= major
  assign done     = (cnt_r == '0);
  assign quotient = quot_r[tasm_pkg::PERIOD_W-1:0];

endmodule

@@ src/tasm_ctrl.sv @@
`timescale 1ns / 1ps

module tasm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tasm_pkg::status_t  sts,
  output tasm_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DSTART,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.start_div ? S_DSTART : S_EMIT;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.wait_load = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = in_ready_r;

endmodule

@@ src/tasm_dp.sv @@
`timescale 1ns / 1ps

module tasm_dp #(
  parameter int PHASE_COUNT = 8,
  parameter int MOVE_BITS   = 15
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tasm_pkg::cmd_t                        cmd,
  output tasm_pkg::status_t                     sts,
  input  logic [tasm_pkg::PERIOD_W-1:0]         period,
  input  logic [1:0]                            in_operation,
  input  logic signed [tasm_pkg::MOVE_W-1:0]    in_move_x,
  input  logic signed [tasm_pkg::MOVE_W-1:0]    in_move_y,
  tasm_out_if.source                            out_ch
);

  localparam logic [tasm_pkg::PHASE_W-1:0] LAST = tasm_pkg::PHASE_W'(PHASE_COUNT - 1);
  localparam logic [31:0] MAG_LIM = 32'((64'd1 << MOVE_BITS) - 64'd1);

  function automatic logic [tasm_pkg::PHASE_W-1:0] phase_next(
    input logic [tasm_pkg::PHASE_W-1:0] ph,
    input logic                         back
  );
    logic [tasm_pkg::PHASE_W-1:0] p;
    p = (ph > LAST) ? LAST : ph;
    if (back) begin
      return (p == '0) ? LAST : p - 1'b1;
    end
    return (p >= LAST) ? '0 : p + 1'b1;
  endfunction

  // magnitude of a two's complement step count, clipped to the counter range
  function automatic logic [MOVE_BITS-1:0] mag_of(input logic [tasm_pkg::MOVE_W-1:0] raw);
    logic [16:0] a;
    a = raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
    return ({15'd0, a} > MAG_LIM) ? MOVE_BITS'(MAG_LIM) : MOVE_BITS'(a);
  endfunction

  // latched request
  logic [1:0]                         op_r;
  logic [tasm_pkg::MOVE_W-1:0]        raw_x_r, raw_y_r;

  logic [tasm_pkg::PHASE_W-1:0]       x_phase_r, y_phase_r;
  logic                               coils_on_r, moving_r;
  logic [MOVE_BITS-1:0]               x_target_r, y_target_r, x_count_r, y_count_r;
  logic                               x_reverse_r, y_reverse_r;
  logic signed [MOVE_BITS:0]          slope_r;
  logic                               major_is_x_r;
  logic [tasm_pkg::WAIT_W-1:0]        major_wait_r, wait_left_r;
  logic [1:0]                         axis_r;
  logic                               done_r, rej_r;
  logic                               out_valid_r;

  logic [MOVE_BITS-1:0]               mx, my, minor, major;
  logic                               zero_move;
  logic                               x_can, y_can;
  logic                               div_done;
  logic [tasm_pkg::PERIOD_W-1:0]      quot;

  assign mx        = mag_of(raw_x_r);
  assign my        = mag_of(raw_y_r);
  assign zero_move = (mx == '0) && (my == '0);
  assign x_can     = (x_count_r < x_target_r) && !slope_r[MOVE_BITS];
  assign y_can     = (y_count_r < y_target_r) &&
                     (slope_r[MOVE_BITS] || (x_count_r >= x_target_r));
  assign major     = major_is_x_r ? x_target_r : y_target_r;
  assign minor     = major_is_x_r ? y_target_r : x_target_r;

  assign sts.start_div = (op_r == tasm_pkg::OP_MOVE) && !moving_r && !zero_move;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  tasm_div #(
    .MOVE_BITS (MOVE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .period   (period),
    .minor    (minor),
    .major    (major),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      raw_x_r <= in_move_x;
      raw_y_r <= in_move_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_phase_r    <= '0;
      y_phase_r    <= '0;
      coils_on_r   <= 1'b0;
      moving_r     <= 1'b0;
      x_target_r   <= '0;
      y_target_r   <= '0;
      x_count_r    <= '0;
      y_count_r    <= '0;
      x_reverse_r  <= 1'b0;
      y_reverse_r  <= 1'b0;
      slope_r      <= '0;
      major_is_x_r <= 1'b0;
      major_wait_r <= '0;
      wait_left_r  <= '0;
    end else if (cmd.exec) begin
      case (op_r)
        tasm_pkg::OP_OFF: begin
          if (!moving_r) begin
            coils_on_r <= 1'b0;
            x_phase_r  <= '0;
            y_phase_r  <= '0;
          end
        end
        tasm_pkg::OP_MOVE: begin
          if (!moving_r && !zero_move) begin
            x_target_r   <= mx;
            y_target_r   <= my;
            x_count_r    <= '0;
            y_count_r    <= '0;
            x_reverse_r  <= raw_x_r[15];
            y_reverse_r  <= raw_y_r[15];
            slope_r      <= '0;
            major_is_x_r <= (mx > my);
            wait_left_r  <= '0;
            coils_on_r   <= 1'b1;
            moving_r     <= 1'b1;
          end
        end
        tasm_pkg::OP_TICK: begin
          if (moving_r) begin
            if (wait_left_r != '0) begin
              wait_left_r <= wait_left_r - 1'b1;
            end else if (x_can) begin
              x_count_r   <= x_count_r + 1'b1;
              slope_r     <= slope_r - $signed({1'b0, y_target_r});
              x_phase_r   <= phase_next(x_phase_r, x_reverse_r);
              wait_left_r <= major_is_x_r ? major_wait_r : '0;
            end else if (y_can) begin
              y_count_r   <= y_count_r + 1'b1;
              slope_r     <= slope_r + $signed({1'b0, x_target_r});
              y_phase_r   <= phase_next(y_phase_r, y_reverse_r);
              wait_left_r <= major_is_x_r ? '0 : major_wait_r;
            end else begin
              moving_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.wait_load) begin
      // period * (|x|+|y|) / major = period + period * minor / major
      major_wait_r <= {1'b0, period} + {1'b0, quot};
    end
  end

  // per-request flags
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      axis_r <= tasm_pkg::AXIS_NONE;
      done_r <= 1'b0;
      rej_r  <= 1'b0;
      case (op_r)
        tasm_pkg::OP_MOVE: begin
          if (moving_r) begin
            rej_r <= 1'b1;
          end else if (zero_move) begin
            done_r <= 1'b1;
          end
        end
        tasm_pkg::OP_OFF: rej_r <= moving_r;
        tasm_pkg::OP_TICK: begin
          if (moving_r && wait_left_r == '0) begin
            if (x_can) begin
              axis_r <= tasm_pkg::AXIS_X;
            end else if (y_can) begin
              axis_r <= tasm_pkg::AXIS_Y;
            end else begin
              done_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch.x_coils      <= coils_on_r ? tasm_pkg::coil_pattern(x_phase_r) : 4'd0;
      out_ch.y_coils      <= coils_on_r ? tasm_pkg::coil_pattern(y_phase_r) : 4'd0;
      out_ch.stepped_axis <= axis_r;
      out_ch.busy_res     <= moving_r;
      out_ch.move_done    <= done_r;
      out_ch.rejected     <= rej_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

@@ src/two_axis_stepper_line_mover_unit.sv @@
`timescale 1ns / 1ps

// two-axis line mover: each request is a tick, a move start or a coils-off, and gives exactly
// one result carrying both coil patterns, which axis stepped, and the busy, done and rejected
// flags. the block takes one request at a time: a tick, an off, a rejected request or a zero
// move passes through the exec and emit states to its result, while a real move start also
// passes the divider start and divide states, where the bit-serial divider works out the
// per-move major-axis wait at one quotient bit per cycle. results sit in an output register,
// so a stalled result only holds the block in its emit state. step_period sits at byte
// address 0 of the config port and may only be written while no request is in flight.
module two_axis_stepper_line_mover_unit #(
  parameter int PHASE_COUNT = 8,
  parameter int MOVE_BITS   = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tasm_in_if.sink                             in_ch,
  tasm_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tasm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tasm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tasm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [tasm_pkg::PERIOD_W-1:0] step_period_r;
  logic                          reg_hit;
  tasm_pkg::cmd_t                cmd;
  tasm_pkg::status_t             sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[tasm_pkg::CFG_ADDR_W-1:2] == tasm_pkg::REG_STEP_PERIOD);
  assign prdata  = reg_hit ? tasm_pkg::CFG_DATA_W'(step_period_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r <= tasm_pkg::STEP_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      step_period_r <= pwdata[tasm_pkg::PERIOD_W-1:0];
    end
  end

  tasm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tasm_dp #(
    .PHASE_COUNT (PHASE_COUNT),
    .MOVE_BITS   (MOVE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .period       (step_period_r),
    .in_operation (in_ch.operation),
    .in_move_x    (in_ch.move_x),
    .in_move_y    (in_ch.move_y),
    .out_ch       (out_ch)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while previous one still in flight");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.move_done && out_ch.busy_res))
    else $error("move reported done while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.rejected) |-> out_ch.busy_res)
    else $error("request rejected with no move in progress");

  a_step_energised: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stepped_axis != tasm_pkg::AXIS_NONE) |->
      (out_ch.x_coils != 4'd0 && out_ch.y_coils != 4'd0))
    else $error("step reported with coils de-energised");
`endif

endmodule
